FILE: rtl/dae_pkg.sv
package dae_pkg;

    // width of the input field and of the number that is converted
    localparam int IN_BITS    = 32;
    localparam int VALUE_BITS = 32;
    localparam int CONV_BITS  = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;

    // decimal digits needed for CONV_BITS bits, floor(n * log10(2)) + 1
    localparam int NUM_DIGITS   = ((CONV_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS     = NUM_DIGITS * 4;
    localparam int CNT_BITS     = $clog2(NUM_DIGITS + 1);
    localparam int DIG_IDX_BITS = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_BITS = $clog2(CONV_BITS + 1);

    // character output
    localparam int CHAR_BITS = 6;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;

    // queue between converter and emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

    // one converted item: packed bcd digits and count of significant digits
    typedef struct packed {
        logic [BCD_BITS-1:0] bcd;
        logic [CNT_BITS-1:0] ndig;
    } q_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SHIFT,
        F_DONE
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

endpackage

FILE: rtl/dae_front.sv
module dae_front
    import dae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_BITS-1:0]   value,
    input  q_status_t            q_status,
    output logic                 q_push,
    output q_entry_t             q_wr_data
);

    front_state_t              state_reg;
    front_state_t              state_next;
    logic [CONV_BITS-1:0]      bin_reg;
    logic [CONV_BITS-1:0]      bin_next;
    logic [BCD_BITS-1:0]       bcd_reg;
    logic [BCD_BITS-1:0]       bcd_next;
    logic [BCD_BITS-1:0]       bcd_adj;
    logic [BIT_CNT_BITS-1:0]   bit_cnt_reg;
    logic [BIT_CNT_BITS-1:0]   bit_cnt_next;
    logic [CNT_BITS-1:0]       ndig;
    logic                      last_bit;

    assign last_bit = (bit_cnt_reg == BIT_CNT_BITS'(CONV_BITS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_SHIFT;
                end
            end
            F_SHIFT:
            begin
                if (last_bit)
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready = 1'b0;
        q_push   = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
            end
            F_DONE:
            begin
                q_push = !q_status.full;
            end
            default:
            begin
                in_ready = 1'b0;
                q_push   = 1'b0;
            end
        endcase
    end

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // double dabble datapath, one input bit per cycle
    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        if (state_reg == F_IDLE && in_valid)
        begin
            bin_next     = value[CONV_BITS-1:0];
            bcd_next     = '0;
            bit_cnt_next = '0;
        end
        else if (state_reg == F_SHIFT)
        begin
            bin_next     = {bin_reg[CONV_BITS-2:0], 1'b0};
            bcd_next     = {bcd_adj[BCD_BITS-2:0], bin_reg[CONV_BITS-1]};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_BITS'(1);
        end
    end

    // significant digit count, at least one for a zero value
    always_comb
    begin
        ndig = CNT_BITS'(1);
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] != 4'd0)
            begin
                ndig = CNT_BITS'(k + 1);
            end
        end
    end

    assign q_wr_data.bcd  = bcd_reg;
    assign q_wr_data.ndig = ndig;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
    end

endmodule

FILE: rtl/dae_queue.sv
module dae_queue
    import dae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  q_entry_t   wr_data,
    input  logic       pop,
    output q_entry_t   rd_data,
    output q_status_t  status
);

    q_entry_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [PTR_BITS:0]    count_reg;
    logic [PTR_BITS:0]    count_next;

    assign status.full  = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");
`endif

endmodule

FILE: rtl/dae_back.sv
module dae_back
    import dae_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_entry_t              q_rd_data,
    input  q_status_t             q_status,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAR_BITS-1:0]  digit_char,
    output logic                  last_digit
);

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [BCD_BITS-1:0]       bcd_reg;
    logic [BCD_BITS-1:0]       bcd_next;
    logic [CNT_BITS-1:0]       cnt_reg;
    logic [CNT_BITS-1:0]       cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [CHAR_BITS-1:0]      char_reg;
    logic [CHAR_BITS-1:0]      char_next;
    logic                      last_reg;
    logic                      last_next;
    logic [3:0]                digits [NUM_DIGITS];
    logic [DIG_IDX_BITS-1:0]   dig_idx;
    logic                      slot_free;
    logic                      emit;
    logic                      run_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign run_last  = (cnt_reg == CNT_BITS'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (slot_free && run_last)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_status.empty;
            end
            B_RUN:
            begin
                emit = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // digit view of the held bcd word, most significant digit picked by count
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            digits[k] = bcd_reg[4*k +: 4];
        end
    end

    assign dig_idx = DIG_IDX_BITS'(cnt_reg - CNT_BITS'(1));

    // run registers and output register
    always_comb
    begin
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            bcd_next = q_rd_data.bcd;
            cnt_next = q_rd_data.ndig;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_ZERO + CHAR_BITS'(digits[dig_idx]);
            last_next      = run_last;
            cnt_next       = cnt_reg - CNT_BITS'(1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

`ifndef SYNTH
    a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg >= CHAR_ZERO && char_reg <= CHAR_ZERO + CHAR_BITS'(9)))
        else $error("emitted character is not a decimal digit");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_RUN |-> (cnt_reg != '0 && cnt_reg <= CNT_BITS'(NUM_DIGITS)))
        else $error("digit count out of range during a run");
`endif

endmodule

FILE: rtl/decimal_ascii_digit_emitter.sv
// The converter accepts a new item only while idle, after it has run the bit-serial
// shift-and-add-3 loop of one step per input bit (32 steps) on the last item and
// handed that item to the queue, a hand-off that waits while the queue is full.
// The emitter sends one digit per cycle while out_ready is high.
// Reset clears the state machines, the queue pointers and the output valid;
// there is no clearing pass and no state carries from one item to the next.
module decimal_ascii_digit_emitter
    import dae_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_BITS-1:0]    value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAR_BITS-1:0]  digit_char,
    output logic                  last_digit
);

    q_status_t  q_status;
    q_entry_t   q_wr_data;
    q_entry_t   q_rd_data;
    logic       q_push;
    logic       q_pop;

    // binary to bcd conversion
    dae_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wr_data (q_wr_data)
    );

    // converted items waiting for the emitter
    dae_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // ascii digit emission
    dae_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd_data  (q_rd_data),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule
